[rtl/mtd_pkg.sv]
package mtd_pkg;

    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_UNKNOWN = 8'h58;

    localparam int TABLE_SIZE = 45;

    // pattern bits: first symbol most significant, dash = 1, dot = 0
    typedef struct packed {
        logic [2:0] len;
        logic [5:0] bits;
        logic [7:0] ch;
    } morse_entry_t;

    localparam morse_entry_t MORSE_TABLE [TABLE_SIZE] = '{
        '{3'd2, 6'b000001, "a"}, '{3'd4, 6'b001000, "b"}, '{3'd4, 6'b001010, "c"},
        '{3'd3, 6'b000100, "d"}, '{3'd1, 6'b000000, "e"}, '{3'd4, 6'b000010, "f"},
        '{3'd3, 6'b000110, "g"}, '{3'd4, 6'b000000, "h"}, '{3'd2, 6'b000000, "i"},
        '{3'd4, 6'b000111, "j"}, '{3'd3, 6'b000101, "k"}, '{3'd4, 6'b000100, "l"},
        '{3'd2, 6'b000011, "m"}, '{3'd2, 6'b000010, "n"}, '{3'd3, 6'b000111, "o"},
        '{3'd4, 6'b000110, "p"}, '{3'd4, 6'b001101, "q"}, '{3'd3, 6'b000010, "r"},
        '{3'd3, 6'b000000, "s"}, '{3'd1, 6'b000001, "t"}, '{3'd3, 6'b000001, "u"},
        '{3'd4, 6'b000001, "v"}, '{3'd3, 6'b000011, "w"}, '{3'd4, 6'b001001, "x"},
        '{3'd4, 6'b001011, "y"}, '{3'd4, 6'b001100, "z"},
        '{3'd5, 6'b011111, "0"}, '{3'd5, 6'b001111, "1"}, '{3'd5, 6'b000111, "2"},
        '{3'd5, 6'b000011, "3"}, '{3'd5, 6'b000001, "4"}, '{3'd5, 6'b000000, "5"},
        '{3'd5, 6'b010000, "6"}, '{3'd5, 6'b011000, "7"}, '{3'd5, 6'b011100, "8"},
        '{3'd5, 6'b011110, "9"},
        '{3'd6, 6'b110011, ","}, '{3'd6, 6'b010101, "."}, '{3'd6, 6'b101010, ";"},
        '{3'd6, 6'b111000, ":"}, '{3'd6, 6'b001100, "?"}, '{3'd4, 6'b001110, "!"},
        '{3'd6, 6'b011110, 8'h27}, '{3'd5, 6'b010110, "("}, '{3'd6, 6'b101101, ")"}
    };

endpackage

[rtl/morse_token_decoder_unit.sv]
// Morse token decoder: takes one ASCII character per request on the s_ side and
// returns one decoded character per finished token on the m_ side. Dots and dashes
// build a token, a lone slash is the word space, whitespace or s_tlast ends the
// token; a token with no table match comes out as 'X' with m_tuser set. One
// character is taken every cycle while s_tready is high; a closing character goes from
// the input register through the decode logic into the result register, which drives
// m_tvalid. The result register holds while m_tready is low, and s_tready falls only
// when an input is waiting, the result register is full and m_tready is low.
module morse_token_decoder_unit #(
    parameter int MAX_CODE_SYMBOLS = 6
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_char
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_char
    output logic       m_tuser    // unknown
);
    import mtd_pkg::*;

    localparam int SW    = MAX_CODE_SYMBOLS;
    localparam int CNT_W = $clog2(MAX_CODE_SYMBOLS + 1);

    logic             in_valid_reg;
    logic [7:0]       in_char_reg;
    logic             in_last_reg;

    logic [SW-1:0]    sym_bits_reg, sym_bits_next;
    logic [CNT_W-1:0] sym_count_reg, sym_count_next;
    logic             slash_reg, slash_next;
    logic             bad_reg, bad_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg, out_char_next;
    logic             out_unk_reg, out_unk_next;

    logic             out_free;
    logic             advance;
    logic             is_blank;
    logic             is_sym;
    logic [SW-1:0]    upd_bits, tok_bits;
    logic [CNT_W-1:0] upd_count, tok_count;
    logic             upd_slash, tok_slash;
    logic             upd_bad, tok_bad;
    logic             flush;
    logic             emit;
    logic             found;
    logic [7:0]       match_char;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_unk_reg;

    // token update for a non-blank character
    always_comb begin
        is_blank  = in_char_reg inside {[8'h09:8'h0D], CHAR_SPACE};
        is_sym    = (in_char_reg == CHAR_DOT) || (in_char_reg == CHAR_DASH);
        upd_bits  = sym_bits_reg;
        upd_count = sym_count_reg;
        upd_slash = slash_reg;
        upd_bad   = bad_reg;
        if (is_sym) begin
            if (slash_reg || (sym_count_reg >= CNT_W'(MAX_CODE_SYMBOLS))) begin
                upd_bad = 1'b1;
            end else if (!bad_reg) begin
                upd_bits  = {sym_bits_reg[SW-2:0], in_char_reg == CHAR_DASH};
                upd_count = sym_count_reg + CNT_W'(1);
            end
        end else if (in_char_reg == CHAR_SLASH) begin
            if (slash_reg || (sym_count_reg != '0)) begin
                upd_bad = 1'b1;
            end else begin
                upd_slash = 1'b1;
            end
        end else if (!is_blank) begin
            upd_bad = 1'b1;
        end
        tok_bits  = is_blank ? sym_bits_reg  : upd_bits;
        tok_count = is_blank ? sym_count_reg : upd_count;
        tok_slash = is_blank ? slash_reg     : upd_slash;
        tok_bad   = is_blank ? bad_reg       : upd_bad;
        flush     = is_blank || in_last_reg;
        emit      = flush && ((tok_count != '0) || tok_slash || tok_bad);
    end

    // table lookup
    always_comb begin
        found      = 1'b0;
        match_char = CHAR_UNKNOWN;
        for (int t = 0; t < TABLE_SIZE; t++) begin
            if (!found && (tok_count == CNT_W'(MORSE_TABLE[t].len))
                    && (tok_bits == SW'(MORSE_TABLE[t].bits))) begin
                found      = 1'b1;
                match_char = MORSE_TABLE[t].ch;
            end
        end
    end

    always_comb begin
        sym_bits_next  = sym_bits_reg;
        sym_count_next = sym_count_reg;
        slash_next     = slash_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_unk_next   = out_unk_reg;
        if (out_free) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            if (flush) begin
                sym_bits_next  = '0;
                sym_count_next = '0;
                slash_next     = 1'b0;
                bad_next       = 1'b0;
            end else begin
                sym_bits_next  = upd_bits;
                sym_count_next = upd_count;
                slash_next     = upd_slash;
                bad_next       = upd_bad;
            end
            out_valid_next = emit;
            if (emit) begin
                if (tok_bad) begin
                    out_char_next = CHAR_UNKNOWN;
                    out_unk_next  = 1'b1;
                end else if (tok_slash && (tok_count == '0)) begin
                    out_char_next = CHAR_SPACE;
                    out_unk_next  = 1'b0;
                end else begin
                    out_char_next = match_char;
                    out_unk_next  = !found;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            sym_bits_reg  <= '0;
            sym_count_reg <= '0;
            slash_reg     <= 1'b0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            sym_bits_reg  <= sym_bits_next;
            sym_count_reg <= sym_count_next;
            slash_reg     <= slash_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        out_char_reg <= out_char_next;
        out_unk_reg  <= out_unk_next;
    end

endmodule

[rtl/mtd_checker.sv]
module mtd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser
);
    import mtd_pkg::*;

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // unknown flag goes with 'X' and only with it
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == (m_tdata == CHAR_UNKNOWN)))
        else $error("unknown flag and character disagree");

    // reset empties the result register
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // input taken whenever the result side is ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled with result side ready");

    // waiting request holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("waiting request changed");

endmodule

bind morse_token_decoder_unit mtd_checker u_mtd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[verif/morse_token_decoder_unit_tb.sv]
`timescale 1ns / 100ps

module morse_token_decoder_unit_tb;
    import mtd_pkg::*;

    localparam int MAX_SYMS = 6;
    localparam int ITEM_TARGET = 1800;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DIR_ROWS = 26;

    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_TAB  = 8'h09;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_FF   = 8'h0C;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_HIGH = 8'hFF;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_GIVEN} row_kind_t;

    typedef struct packed {
        logic [7:0] c;
        logic       last;
        row_kind_t  kind;
        logic [7:0] ech;
        logic       eunk;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       unknown;
    } decoded_t;

    typedef struct packed {
        logic [2:0] len;
        logic [5:0] bits;
        logic [7:0] ch;
    } code_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tuser;

    code_t      code_book[$];
    decoded_t   decoded_chars_q[$];

    logic [5:0] tok_bits;
    int         tok_count;
    logic       tok_slash;
    logic       tok_bad;

    int cycles;
    int err_count;
    int items_sent;
    int burst_left;

    stim_row_t dir_table [DIR_ROWS] = '{
        '{CHAR_FF,    1'b1, ROW_SILENT,  CHAR_NUL,     1'b0},
        '{CHAR_NUL,   1'b1, ROW_GIVEN,   CHAR_UNKNOWN, 1'b1},
        '{CHAR_SLASH, 1'b1, ROW_GIVEN,   CHAR_SPACE,   1'b0},
        '{CHAR_SLASH, 1'b0, ROW_PREDICT, CHAR_NUL,     1'b0},
        '{CHAR_SLASH, 1'b0, ROW_PREDICT, CHAR_NUL,     1'b0},
        '{CHAR_CR,    1'b0, ROW_GIVEN,   CHAR_UNKNOWN, 1'b1},
        '{CHAR_DASH,  1'b0, ROW_PREDICT, CHAR_NUL,     1'b0},
        '{CHAR_SLASH, 1'b1, ROW_GIVEN,   CHAR_UNKNOWN, 1'b1},
        '{CHAR_SLASH, 1'b0, ROW_PREDICT, CHAR_NUL,     1'b0},
        '{CHAR_DOT,   1'b1, ROW_GIVEN,   CHAR_UNKNOWN, 1'b1},
        '{CHAR_DASH,  1'b0, ROW_PREDICT, CHAR_NUL,     1'b0},
        '{CHAR_DOT,   1'b0, ROW_PREDICT, CHAR_NUL,     1'b0},
        '{CHAR_DASH,  1'b0, ROW_PREDICT, CHAR_NUL,     1'b0},
        '{CHAR_DASH,  1'b0, ROW_PREDICT, CHAR_NUL,     1'b0},
        '{CHAR_DOT,   1'b0, ROW_PREDICT, CHAR_NUL,     1'b0},
        '{CHAR_DASH,  1'b0, ROW_PREDICT, CHAR_NUL,     1'b0},
        '{CHAR_SPACE, 1'b1, ROW_GIVEN,   ")",          1'b0},
        '{CHAR_DASH,  1'b0, ROW_PREDICT, CHAR_NUL,     1'b0},
        '{CHAR_DASH,  1'b0, ROW_PREDICT, CHAR_NUL,     1'b0},
        '{CHAR_DASH,  1'b0, ROW_PREDICT, CHAR_NUL,     1'b0},
        '{CHAR_DASH,  1'b0, ROW_PREDICT, CHAR_NUL,     1'b0},
        '{CHAR_DASH,  1'b0, ROW_PREDICT, CHAR_NUL,     1'b0},
        '{CHAR_DASH,  1'b0, ROW_PREDICT, CHAR_NUL,     1'b0},
        '{CHAR_DASH,  1'b1, ROW_GIVEN,   CHAR_UNKNOWN, 1'b1},
        '{CHAR_HIGH,  1'b0, ROW_PREDICT, CHAR_NUL,     1'b0},
        '{CHAR_LF,    1'b0, ROW_GIVEN,   CHAR_UNKNOWN, 1'b1}
    };

    morse_token_decoder_unit #(
        .MAX_CODE_SYMBOLS(MAX_SYMS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    task automatic add_code(input string pat, input logic [7:0] ch);
        code_t e;
        e.len = 3'(pat.len());
        e.bits = '0;
        e.ch = ch;
        for (int i = 0; i < pat.len(); i++) begin
            e.bits = {e.bits[4:0], pat[i] == "-"};
        end
        code_book.push_back(e);
    endtask

    function automatic logic is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic logic close_token(output decoded_t res);
        res.ch = CHAR_UNKNOWN;
        res.unknown = 1'b1;
        if (tok_count == 0 && !tok_slash && !tok_bad) begin
            return 1'b0;
        end
        if (!tok_bad && tok_slash && tok_count == 0) begin
            res.ch = CHAR_SPACE;
            res.unknown = 1'b0;
        end else if (!tok_bad) begin
            foreach (code_book[i]) begin
                if (res.unknown && int'(code_book[i].len) == tok_count
                        && code_book[i].bits == tok_bits) begin
                    res.ch = code_book[i].ch;
                    res.unknown = 1'b0;
                end
            end
        end
        tok_bits = '0;
        tok_count = 0;
        tok_slash = 1'b0;
        tok_bad = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic morse_decode_step(input logic [7:0] c, input logic last,
                                               output decoded_t res);
        res = '0;
        if (is_blank(c)) begin
            return close_token(res);
        end
        if (c == CHAR_DOT || c == CHAR_DASH) begin
            if (tok_slash || tok_count >= MAX_SYMS) begin
                tok_bad = 1'b1;
            end else if (!tok_bad) begin
                tok_bits = {tok_bits[4:0], c == CHAR_DASH};
                tok_count++;
            end
        end else if (c == CHAR_SLASH) begin
            if (tok_slash || tok_count != 0) begin
                tok_bad = 1'b1;
            end else begin
                tok_slash = 1'b1;
            end
        end else begin
            tok_bad = 1'b1;
        end
        if (last) begin
            return close_token(res);
        end
        return 1'b0;
    endfunction

    function automatic stim_row_t pred_row(input logic [7:0] c, input logic last);
        stim_row_t r;
        r = '0;
        r.c = c;
        r.last = last;
        r.kind = ROW_PREDICT;
        return r;
    endfunction

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CHAR_SPACE : CHAR_TAB + r[7:0];
    endfunction

    // one request, with the burst and gap pattern of the sender
    task automatic send_req(input stim_row_t row);
        int gap;
        decoded_t res;
        logic has_res;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= row.c;
        s_tlast <= row.last;
        has_res = morse_decode_step(row.c, row.last, res);
        if (row.kind == ROW_GIVEN) begin
            res.ch = row.ech;
            res.unknown = row.eunk;
            decoded_chars_q.push_back(res);
        end else if (row.kind == ROW_PREDICT && has_res) begin
            decoded_chars_q.push_back(res);
        end
        items_sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic finish_token(input logic eot_used);
        if (!eot_used) begin
            send_req(pred_row(pick_blank(), $urandom_range(0, 3) == 0));
        end
        // runs of blanks give empty tokens
        if ($urandom_range(0, 7) == 0) begin
            send_req(pred_row(pick_blank(), 1'($urandom_range(0, 1))));
        end
    endtask

    task automatic send_random_token();
        int kind;
        int n;
        int r;
        logic eot_close;
        logic [7:0] c;
        code_t e;
        kind = $urandom_range(0, 99);
        eot_close = $urandom_range(0, 3) == 0;
        if (kind < 60) begin
            e = code_book[$urandom_range(0, code_book.size() - 1)];
            for (int i = int'(e.len) - 1; i >= 0; i--) begin
                c = e.bits[i] ? CHAR_DASH : CHAR_DOT;
                send_req(pred_row(c, eot_close && i == 0));
            end
            finish_token(eot_close);
        end else if (kind < 70) begin
            send_req(pred_row(CHAR_SLASH, eot_close));
            finish_token(eot_close);
        end else if (kind < 85) begin
            n = $urandom_range(1, 9);
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(0, 9);
                if (r < 4) begin
                    c = CHAR_DOT;
                end else if (r < 8) begin
                    c = CHAR_DASH;
                end else if (r == 8) begin
                    c = CHAR_SLASH;
                end else begin
                    c = 8'($urandom_range(0, 255));
                end
                send_req(pred_row(c, eot_close && i == n - 1));
            end
            finish_token(eot_close);
        end else begin
            send_req(pred_row(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0));
        end
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stall pattern, stepping through four modes by the cycle counter
    always @(negedge aclk) begin
        case ((cycles >> 9) & 3)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_tready <= (cycles % 4) == 0;
            end
            default: begin
                m_tready <= $urandom_range(0, 6) != 0;
            end
        endcase
    end

    always @(posedge aclk) begin
        decoded_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_chars_q.size() == 0) begin
                $display("%0t: unexpected result char %h unknown %0d", $time, m_tdata,
                         m_tuser);
                err_count++;
            end else begin
                exp_res = decoded_chars_q.pop_front();
                if (m_tdata !== exp_res.ch) begin
                    $display("%0t: char mismatch, expected %h actual %h", $time,
                             exp_res.ch, m_tdata);
                    err_count++;
                end
                if (m_tuser !== exp_res.unknown) begin
                    $display("%0t: unknown flag mismatch, expected %0d actual %0d", $time,
                             exp_res.unknown, m_tuser);
                    err_count++;
                end
            end
        end
    end

    initial begin
        logic paused;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        items_sent = 0;
        burst_left = 0;
        paused = 1'b0;
        tok_bits = '0;
        tok_count = 0;
        tok_slash = 1'b0;
        tok_bad = 1'b0;

        add_code(".-", "a");     add_code("-...", "b");   add_code("-.-.", "c");
        add_code("-..", "d");    add_code(".", "e");      add_code("..-.", "f");
        add_code("--.", "g");    add_code("....", "h");   add_code("..", "i");
        add_code(".---", "j");   add_code("-.-", "k");    add_code(".-..", "l");
        add_code("--", "m");     add_code("-.", "n");     add_code("---", "o");
        add_code(".--.", "p");   add_code("--.-", "q");   add_code(".-.", "r");
        add_code("...", "s");    add_code("-", "t");      add_code("..-", "u");
        add_code("...-", "v");   add_code(".--", "w");    add_code("-..-", "x");
        add_code("-.--", "y");   add_code("--..", "z");
        add_code("-----", "0");  add_code(".----", "1");  add_code("..---", "2");
        add_code("...--", "3");  add_code("....-", "4");  add_code(".....", "5");
        add_code("-....", "6");  add_code("--...", "7");  add_code("---..", "8");
        add_code("----.", "9");
        add_code("--..--", ","); add_code(".-.-.-", "."); add_code("-.-.-.", ";");
        add_code("---...", ":"); add_code("..--..", "?"); add_code("---.", "!");
        add_code(".----.", 8'h27); add_code("-.--.", "("); add_code("-.--.-", ")");

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_req(dir_table[i]);
        end

        while (items_sent < ITEM_TARGET) begin
            if (!paused && items_sent >= ITEM_TARGET / 2) begin
                // hold off until the result side has drained
                paused = 1'b1;
                @(negedge aclk);
                s_tvalid <= 1'b0;
                while (decoded_chars_q.size() != 0) @(posedge aclk);
                burst_left = 0;
            end
            send_random_token();
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;

        while (decoded_chars_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
